@@ sv/alzette_spn_layer_unit_core_defines.svh @@
// Assertion macros shared by the checker of the Alzette SPN layer unit.
`ifndef ALZETTE_SPN_LAYER_UNIT_CORE_DEFINES_SVH
`define ALZETTE_SPN_LAYER_UNIT_CORE_DEFINES_SVH

// Checked only while out of reset.
`define ASU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASU_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/asu_pkg.sv @@
// Types, constants and helper functions of the Alzette SPN layer unit.
package asu_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumSteps = 4;

  localparam logic [WordW-1:0] BoxConstReset = 32'hb7e15162;

  // Rotate amounts of the four forward box steps: y += rotr(x, a); x ^= rotr(y, b).
  localparam int unsigned RotA [NumSteps] = '{31, 17, 0, 23};
  localparam int unsigned RotB [NumSteps] = '{24, 17, 31, 16};

  localparam int unsigned LinRot = 7;

  typedef enum logic [1:0] {
    CmdBoxFwd = 2'd0,
    CmdBoxInv = 2'd1,
    CmdLinFwd = 2'd2,
    CmdLinInv = 2'd3
  } asu_cmd_e;

  typedef struct packed {
    asu_cmd_e         cmd;
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
    logic [WordW-1:0] w;
  } asu_item_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int unsigned n);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} >> (n % WordW);
    return dbl[WordW-1:0];
  endfunction

endpackage

@@ sv/asu_stage.sv @@
// One pipeline stage: a single forward or inverse ARX box step plus its item register; linear commands pass unchanged.
module asu_stage #(
  parameter int unsigned StepIdx = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [asu_pkg::WordW-1:0] k_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  asu_pkg::asu_item_t      item_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output asu_pkg::asu_item_t      item_o
);
  import asu_pkg::*;

  // The inverse box undoes the forward steps in reverse order.
  localparam int unsigned FwdIdx = StepIdx;
  localparam int unsigned InvIdx = NumSteps - 1 - StepIdx;

  logic               valid_q;
  asu_item_t          item_q;
  asu_item_t          item_d;
  logic [WordW-1:0]   fy1;
  logic [WordW-1:0]   fx1;
  logic [WordW-1:0]   iy1;
  logic [WordW-1:0]   ix1;

  always_comb begin
    fy1 = item_i.y + rotr(item_i.x, RotA[FwdIdx]);
    fx1 = item_i.x ^ rotr(fy1, RotB[FwdIdx]);
    iy1 = item_i.y ^ k_i;
    ix1 = item_i.x ^ rotr(iy1, RotB[InvIdx]);

    item_d = item_i;
    case (item_i.cmd)
      CmdBoxFwd: begin
        item_d.x = fx1;
        item_d.y = fy1 ^ k_i;
      end
      CmdBoxInv: begin
        item_d.x = ix1;
        item_d.y = iy1 - rotr(ix1, RotA[InvIdx]);
      end
      default: begin
        item_d = item_i;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ sv/alzette_spn_layer_unit_core.sv @@
// Top level of the Alzette SPN layer unit: linear layer and four-stage ARX box pipeline.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid_i/in_ready_o  command_i, word_x_i..word_w_i
//   out       source     out_valid_o/out_ready_i out_x_o..out_w_o
//   cfg       sink       cfg_we_i               cfg_wdata_i (box constant)
//
// An item accepted into the first stage register moves through the four ARX step stage
// registers in order, one register per ARX step stage, and raises out_valid_o from the last.
// While the output does not stall, one item may enter in every cycle; throughput is one item per cycle.
// The linear layer commands are worked out ahead of the first stage and ride along.
// When the output stalls, the stages fill up and in_ready_o drops once all four are full.
// Reset empties the pipeline and loads the box constant with its default value.
module alzette_spn_layer_unit_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                command_i,
  input  logic [asu_pkg::WordW-1:0] word_x_i,
  input  logic [asu_pkg::WordW-1:0] word_y_i,
  input  logic [asu_pkg::WordW-1:0] word_z_i,
  input  logic [asu_pkg::WordW-1:0] word_w_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [asu_pkg::WordW-1:0] out_x_o,
  output logic [asu_pkg::WordW-1:0] out_y_o,
  output logic [asu_pkg::WordW-1:0] out_z_o,
  output logic [asu_pkg::WordW-1:0] out_w_o,
  input  logic                      cfg_we_i,
  input  logic [asu_pkg::WordW-1:0] cfg_wdata_i
);
  import asu_pkg::*;

  logic [WordW-1:0] box_const_q;
  asu_item_t        lin_item;
  asu_item_t        stage_item  [NumSteps+1];
  logic             stage_valid [NumSteps+1];
  logic             stage_ready [NumSteps+1];
  logic [WordW-1:0] mix_a;
  logic [WordW-1:0] mix_b;
  logic [WordW-1:0] mix_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_const_q <= BoxConstReset;
    end else if (cfg_we_i) begin
      box_const_q <= cfg_wdata_i;
    end
  end

  // The forward layer mixes x,y into z,w; the inverse mixes z,w into x,y.
  always_comb begin
    mix_a = (command_i == CmdLinFwd) ? word_x_i : word_z_i;
    mix_b = (command_i == CmdLinFwd) ? word_y_i : word_w_i;
    mix_t = rotr(mix_a ^ mix_b, LinRot);

    lin_item.cmd = asu_cmd_e'(command_i);
    lin_item.x   = word_x_i;
    lin_item.y   = word_y_i;
    lin_item.z   = word_z_i;
    lin_item.w   = word_w_i;
    case (asu_cmd_e'(command_i))
      CmdLinFwd: begin
        lin_item.x = word_z_i ^ mix_a ^ mix_t;
        lin_item.y = word_w_i ^ mix_b ^ mix_t;
        lin_item.z = word_x_i;
        lin_item.w = word_y_i;
      end
      CmdLinInv: begin
        lin_item.x = word_z_i;
        lin_item.y = word_w_i;
        lin_item.z = word_x_i ^ mix_a ^ mix_t;
        lin_item.w = word_y_i ^ mix_b ^ mix_t;
      end
      default: begin
        lin_item.x = word_x_i;
      end
    endcase
  end

  assign stage_item[0]  = lin_item;
  assign stage_valid[0] = in_valid_i;
  assign in_ready_o     = stage_ready[0];

  for (genvar i = 0; i < NumSteps; i++) begin : g_stage
    asu_stage #(
      .StepIdx(i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .k_i    (box_const_q),
      .valid_i(stage_valid[i]),
      .ready_o(stage_ready[i]),
      .item_i (stage_item[i]),
      .valid_o(stage_valid[i+1]),
      .ready_i(stage_ready[i+1]),
      .item_o (stage_item[i+1])
    );
  end

  assign stage_ready[NumSteps] = out_ready_i;
  assign out_valid_o           = stage_valid[NumSteps];
  assign out_x_o               = stage_item[NumSteps].x;
  assign out_y_o               = stage_item[NumSteps].y;
  assign out_z_o               = stage_item[NumSteps].z;
  assign out_w_o               = stage_item[NumSteps].w;

endmodule

@@ sv/asu_checker.sv @@
// Port-level checker of the Alzette SPN layer unit and its bind to the top level.
`include "alzette_spn_layer_unit_core_defines.svh"

module asu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [asu_pkg::WordW-1:0] out_x_o,
  input logic [asu_pkg::WordW-1:0] out_y_o,
  input logic [asu_pkg::WordW-1:0] out_z_o,
  input logic [asu_pkg::WordW-1:0] out_w_o
);
  import asu_pkg::*;

  logic               in_take;
  logic               out_stall;
  logic [4*WordW-1:0] out_words;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_words = {out_w_o, out_z_o, out_y_o, out_x_o};

  `ASU_ASSERT_ANY(a_empty_in_reset, !rst_ni |-> !out_valid_o, "out_valid_o high during reset")

  `ASU_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_words), "stalled item changed")

  // Input back-pressure only happens with a full pipeline behind a stalled output.
  `ASU_ASSERT(a_full_stall, !in_ready_o |-> out_stall, "in_ready_o low without output stall")

  // With the output draining, an item reaches the output after four stages.
  `ASU_ASSERT(a_latency, in_take ##1 out_ready_i [*3] |=> out_valid_o, "item late at the output")

endmodule

bind alzette_spn_layer_unit_core asu_checker u_asu_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the Alzette SPN layer unit core with a scoreboard class.
module tb_top;
  import asu_pkg::*;

  typedef logic [WordW-1:0] word_t;
  // Four result words, index 0 holds x and index 3 holds w.
  typedef logic [3:0][WordW-1:0] quad_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 125;

  class spn_scoreboard;
    word_t       box_key;
    quad_t       awaited[$];
    int unsigned mismatches;
    int unsigned add_rot[4];
    int unsigned xor_rot[4];
    string       lane[4];

    function new();
      box_key    = BoxConstReset;
      mismatches = 0;
      add_rot    = '{31, 17, 0, 23};
      xor_rot    = '{24, 17, 31, 16};
      lane       = '{"out_x", "out_y", "out_z", "out_w"};
    endfunction

    function void set_key(word_t k);
      box_key = k;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function word_t rotate_right(word_t v, int unsigned n);
      if (n == 0) return v;
      return (v >> n) | (v << (WordW - n));
    endfunction

    function quad_t transform(asu_item_t it);
      word_t x;
      word_t y;
      word_t t;
      quad_t r;
      x = it.x;
      y = it.y;
      case (it.cmd)
        CmdBoxFwd: begin
          for (int s = 0; s < 4; s++) begin
            y = y + rotate_right(x, add_rot[s]);
            x = x ^ rotate_right(y, xor_rot[s]);
            y = y ^ box_key;
          end
          r = {it.w, it.z, y, x};
        end
        CmdBoxInv: begin
          // The steps of the forward box are undone from last to first.
          for (int s = 3; s >= 0; s--) begin
            y = y ^ box_key;
            x = x ^ rotate_right(y, xor_rot[s]);
            y = y - rotate_right(x, add_rot[s]);
          end
          r = {it.w, it.z, y, x};
        end
        CmdLinFwd: begin
          t = rotate_right(it.x ^ it.y, LinRot);
          r = {it.y, it.x, it.w ^ it.y ^ t, it.z ^ it.x ^ t};
        end
        default: begin
          t = rotate_right(it.z ^ it.w, LinRot);
          r = {it.y ^ it.w ^ t, it.x ^ it.z ^ t, it.w, it.z};
        end
      endcase
      return r;
    endfunction

    function void note_item(asu_item_t it);
      awaited.push_back(transform(it));
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(quad_t got);
      quad_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %h arrived with no item outstanding", got));
        return;
      end
      want = awaited.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want[i]) begin
          report($sformatf("%s got %h, expected %h", lane[i], got[i], want[i]));
        end
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  word_t       word_x_i;
  word_t       word_y_i;
  word_t       word_z_i;
  word_t       word_w_i;
  logic        out_valid_o;
  logic        out_ready_i;
  word_t       out_x_o;
  word_t       out_y_o;
  word_t       out_z_o;
  word_t       out_w_o;
  logic        cfg_we_i;
  word_t       cfg_wdata_i;

  spn_scoreboard sb = new();
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_cycles;
  int unsigned   cycle_count;
  asu_item_t     taken_item;
  quad_t         seen_result;

  alzette_spn_layer_unit_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .word_x_i   (word_x_i),
    .word_y_i   (word_y_i),
    .word_z_i   (word_z_i),
    .word_w_i   (word_w_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o),
    .out_w_o    (out_w_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // A long hold-off takes precedence over the random stall pattern.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Results are checked before the item taken at the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen_result = {out_w_o, out_z_o, out_y_o, out_x_o};
        sb.check_result(seen_result);
      end
      if (in_valid_i && in_ready_o) begin
        taken_item = '{cmd: asu_cmd_e'(command_i), x: word_x_i, y: word_y_i,
                       z: word_z_i, w: word_w_i};
        sb.note_item(taken_item);
      end
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WordW - 1);
      3:       return ~(word_t'(1) << $urandom_range(WordW - 1));
      default: return $urandom();
    endcase
  endfunction

  // Returns at the rising edge where the item was taken.
  task automatic send_item(input asu_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= it.cmd;
    word_x_i   <= it.x;
    word_y_i   <= it.y;
    word_z_i   <= it.z;
    word_w_i   <= it.w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_key(input word_t k);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_key(k);
  endtask

  initial begin
    asu_item_t it;
    word_t     phase_key[NumPhases];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = '0;
    word_x_i    = '0;
    word_y_i    = '0;
    word_z_i    = '0;
    word_w_i    = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    cycle_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every command on all-zero, all-one, edge-bit and random words, reset constant.
    for (int c = 0; c < 4; c++) begin
      for (int p = 0; p < 4; p++) begin
        it.cmd = asu_cmd_e'(c);
        case (p)
          0: begin it.x = '0; it.y = '0; it.z = '0; it.w = '0; end
          1: begin it.x = '1; it.y = '1; it.z = '1; it.w = '1; end
          2: begin
            it.x = 32'h8000_0000;
            it.y = 32'h0000_0001;
            it.z = 32'h7fff_ffff;
            it.w = 32'hffff_fffe;
          end
          default: begin
            it.x = $urandom();
            it.y = $urandom();
            it.z = $urandom();
            it.w = $urandom();
          end
        endcase
        send_item(it);
      end
    end

    phase_key = '{32'h0000_0000, 32'hffff_ffff, 32'h0, 32'h8000_0001,
                  32'h0, BoxConstReset, 32'h0000_0001, 32'h0};
    phase_key[2] = $urandom();
    phase_key[4] = $urandom();
    phase_key[7] = $urandom();

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_key(phase_key[ph]);
      @(posedge clk_i);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      // Hold the output back while items keep coming so the pipeline fills up.
      if (ph == 4) hold_cycles = 60;
      for (int n = 0; n < PhaseItems; n++) begin
        it.cmd = asu_cmd_e'($urandom_range(3));
        it.x   = pick_word();
        it.y   = pick_word();
        it.z   = pick_word();
        it.w   = pick_word();
        send_item(it);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/asu_pkg.sv
sv/asu_stage.sv
sv/alzette_spn_layer_unit_core.sv
sv/asu_checker.sv
tb/sv/tb_top.sv
